// ===== hw/rtl/ittfr_pkg.sv =====
// ----------------------------------------------------------------------------
// ittfr_pkg
// Shared constants, types and codes for the idle timeout frame receiver.
// ----------------------------------------------------------------------------
package ittfr_pkg;

  // Frame buffer geometry
  localparam int FRAME_BYTES = 16;
  localparam int ADDR_W      = $clog2(FRAME_BYTES);
  localparam int CNT_W       = ADDR_W + 1;

  // Gain set: six big-endian 16-bit words after the header
  localparam int GAIN_W    = 16;
  localparam int NUM_GAINS = 6;
  localparam int HDR_BYTES = 4;

  // Header pattern
  localparam logic [7:0] HDR_B0 = 8'h8A;
  localparam logic [7:0] HDR_B1 = 8'h8B;
  localparam logic [7:0] HDR_B2 = 8'h1C;
  localparam logic [7:0] HDR_B3 = 8'hAE;

  // Timeout register
  localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd10;
  localparam logic [15:0] IDLE_MAX         = 16'hFFFF;

  // Word codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef logic [GAIN_W-1:0]                 gain_t;
  typedef logic [NUM_GAINS-1:0][GAIN_W-1:0]  gain_set_t;

  // Control strobes from sequencer to frame store
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              close;
  } ittfr_ctl_t;

endpackage

// ===== hw/rtl/ittfr_if.sv =====
// ----------------------------------------------------------------------------
// ittfr stream interfaces
// Valid/ready channels for received words and frame results.
// ----------------------------------------------------------------------------
interface ittfr_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface ittfr_out_if;
  logic        valid;
  logic        ready;
  logic        header_ok;
  logic [15:0] core_p;
  logic [15:0] core_i;
  logic [15:0] core_d;
  logic [15:0] shell_p;
  logic [15:0] shell_i;
  logic [15:0] shell_d;

  modport source (output valid, output header_ok, output core_p, output core_i,
                  output core_d, output shell_p, output shell_i, output shell_d,
                  input ready);
  modport sink   (input valid, input header_ok, input core_p, input core_i,
                  input core_d, input shell_p, input shell_i, input shell_d,
                  output ready);
endinterface

// ===== hw/rtl/ittfr_frame_store.sv =====
// ----------------------------------------------------------------------------
// ittfr_frame_store
// Frame byte buffer, header match and held gain set.
// ----------------------------------------------------------------------------
module ittfr_frame_store import ittfr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  ittfr_ctl_t ctl,
  input  logic [7:0] wr_data,
  output logic       hdr_ok,
  output gain_set_t  gains_nxt
);

  logic [FRAME_BYTES-1:0][7:0] buf_r;
  gain_set_t                   gain_r;
  gain_set_t                   gain_frame;

  // Byte buffer, no reset; the header and gain reads do not check that a byte was written
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      buf_r[ctl.wr_addr] <= wr_data;
    end
  end

  // Header check on fixed positions
  assign hdr_ok = (buf_r[0] == HDR_B0) && (buf_r[1] == HDR_B1) &&
                  (buf_r[2] == HDR_B2) && (buf_r[3] == HDR_B3);

  // Big-endian gain words from the frame body
  always_comb begin
    for (int k = 0; k < NUM_GAINS; k++) begin
      gain_frame[k] = {buf_r[HDR_BYTES + 2*k], buf_r[HDR_BYTES + 2*k + 1]};
    end
  end

  assign gains_nxt = hdr_ok ? gain_frame : gain_r;

  // Held gains, loaded on a closing tick with a good header
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= '0;
    end else if (ctl.close) begin
      gain_r <= gains_nxt;
    end
  end

endmodule

// ===== hw/rtl/ittfr_ctrl.sv =====
// ----------------------------------------------------------------------------
// ittfr_ctrl
// Byte count, receive phase and idle tick counter; timeout register.
// ----------------------------------------------------------------------------
module ittfr_ctrl import ittfr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        stg_valid,
  input  logic        stg_opcode,
  input  logic        out_free,
  output logic        fire,
  output ittfr_ctl_t  ctl
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             rcv_r, rcv_nxt;
  logic             bst_r, bst_nxt;
  logic [15:0]      idle_r, idle_nxt;
  logic [15:0]      timeout_r;
  logic [15:0]      idle_inc;
  logic             tick;
  logic             closes;
  logic             room;

  // Timeout register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= IDLE_TIMEOUT_RST;
    end else if (cfg_wr_en) begin
      timeout_r <= cfg_wr_data;
    end
  end

  // Close decision for the staged word
  assign tick     = (stg_opcode == OP_TICK);
  assign room     = (count_r < CNT_W'(FRAME_BYTES));
  assign idle_inc = (idle_r == IDLE_MAX) ? idle_r : idle_r + 16'd1;
  assign closes   = tick && rcv_r && !bst_r && (idle_inc >= timeout_r);

  // A closing tick waits for a free result register
  assign fire = stg_valid && (!closes || out_free);

  assign ctl.wr_en   = fire && !tick && room;
  assign ctl.wr_addr = count_r[ADDR_W-1:0];
  assign ctl.close   = fire && closes;

  // Next state
  always_comb begin
    count_nxt = count_r;
    rcv_nxt   = rcv_r;
    bst_nxt   = bst_r;
    idle_nxt  = idle_r;
    if (fire) begin
      if (!tick) begin
        if (room) begin
          count_nxt = count_r + CNT_W'(1);
          bst_nxt   = 1'b1;
        end
      end else if (!rcv_r) begin
        if (count_r != '0) begin
          rcv_nxt = 1'b1;
          bst_nxt = 1'b0;
        end
      end else if (bst_r) begin
        bst_nxt  = 1'b0;
        idle_nxt = '0;
      end else if (closes) begin
        count_nxt = '0;
        rcv_nxt   = 1'b0;
        bst_nxt   = 1'b0;
        idle_nxt  = '0;
      end else begin
        idle_nxt = idle_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      rcv_r   <= 1'b0;
      bst_r   <= 1'b0;
      idle_r  <= '0;
    end else begin
      count_r <= count_nxt;
      rcv_r   <= rcv_nxt;
      bst_r   <= bst_nxt;
      idle_r  <= idle_nxt;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(FRAME_BYTES))
    else $error("byte count past buffer size");

  a_rcv_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    rcv_r |-> (count_r != '0))
    else $error("receiving with empty buffer");

  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.close |=> (count_r == '0) && !rcv_r && (idle_r == '0))
    else $error("state not cleared after close");

  a_byte_keeps_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !tick) |=> (idle_r == $past(idle_r)))
    else $error("byte word moved idle counter");

endmodule

// ===== hw/rtl/idle_timeout_frame_receiver_core.sv =====
// ----------------------------------------------------------------------------
// idle_timeout_frame_receiver_core
// Idle-line timeout frame receiver: buffers bytes, closes on idle ticks.
// ----------------------------------------------------------------------------
// Each word (byte or poll tick) is taken into an input register and handled
// from there, so one word is accepted every clock while results flow.
// A tick that closes a frame loads the result register; if that register
// still holds an untaken result, the closing tick waits in the input register
// and input stalls until the sink takes the previous result. Bytes past the
// 16-byte buffer are dropped. The timeout register resets to 10 and should
// only be written while no word is in flight.
module idle_timeout_frame_receiver_core import ittfr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  ittfr_in_if.sink    in_ch,
  ittfr_out_if.source out_ch
);

  logic       stg_v_r;
  logic       stg_op_r;
  logic [7:0] stg_byte_r;
  logic       fire;
  logic       out_free;
  ittfr_ctl_t ctl;
  logic       hdr_ok;
  gain_set_t  gains_nxt;
  logic       out_v_r;
  logic       out_ok_r;
  gain_set_t  out_gain_r;

  // Input register
  assign in_ch.ready = !stg_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      stg_v_r <= 1'b1;
    end else if (fire) begin
      stg_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      stg_op_r   <= in_ch.opcode;
      stg_byte_r <= in_ch.rx_byte;
    end
  end

  ittfr_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .stg_valid   (stg_v_r),
    .stg_opcode  (stg_op_r),
    .out_free    (out_free),
    .fire        (fire),
    .ctl         (ctl)
  );

  ittfr_frame_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .wr_data   (stg_byte_r),
    .hdr_ok    (hdr_ok),
    .gains_nxt (gains_nxt)
  );

  // Result register
  assign out_free = !out_v_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (ctl.close) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.close) begin
      out_ok_r   <= hdr_ok;
      out_gain_r <= gains_nxt;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.header_ok = out_ok_r;
  assign out_ch.core_p    = out_gain_r[0];
  assign out_ch.core_i    = out_gain_r[1];
  assign out_ch.core_d    = out_gain_r[2];
  assign out_ch.shell_p   = out_gain_r[3];
  assign out_ch.shell_i   = out_gain_r[4];
  assign out_ch.shell_d   = out_gain_r[5];

endmodule
